// ----- sv/arc_pkg.sv -----
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and constants of the adaptive replacement cache: slot counts,
// list tags and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int CAPACITY  = 16;
    localparam int SLOTS     = 2 * CAPACITY;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int CAP_W     = 5;
    localparam int DATA_W    = 32;
    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // List tag of a slot; the empty slot is the reset value
    typedef enum logic [2:0] {
        TAG_NONE = 3'd0,
        TAG_T1   = 3'd1,
        TAG_T2   = 3'd2,
        TAG_B1   = 3'd3,
        TAG_B2   = 3'd4
    } tag_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SCAN,
        OP_UNLINK_S,
        OP_LINK_S,
        OP_TAIL,
        OP_UNLINK_TAIL,
        OP_LINK_TAIL,
        OP_FREE,
        OP_LINK_FREE,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_ADAPT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        tag_t   tag;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic kind;
        tag_t where;
        logic evict_t1;
        logic l1_ge_c;
        logic n1_lt_c;
        logic total_ge_c;
        logic total_ge_2c;
        logic div_done;
    } dp_status_t;

endpackage

// ----- sv/arc_dp.sv -----
// ----------------------------------------------------------------------------
// arc_dp
// Datapath of the cache: key and value memories, per-slot list tags and
// ranks, list lengths, target p, the key scan and a small serial divider.
// ----------------------------------------------------------------------------
module arc_dp
    import arc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CAP_W-1:0]    cfg_wdata,
    input  logic                kind,
    input  logic [DATA_W-1:0]   key,
    input  logic [DATA_W-1:0]   write_value,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    output logic                hit,
    output logic [2:0]          where_found,
    output logic [DATA_W-1:0]   read_value
);

    // Storage
    logic [DATA_W-1:0] key_mem [SLOTS];
    logic [DATA_W-1:0] val_mem [SLOTS];
    tag_t              tag_reg [SLOTS];
    logic [SLOT_W-1:0] rank_reg [SLOTS];
    logic [CNT_W-1:0]  len_reg [4];
    logic [CAP_W-1:0]  p_reg;
    logic [CAP_W-1:0]  cap_reg;

    // Item and scan
    logic              kind_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] wval_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              vld_d_reg;
    logic [SLOT_W-1:0] idx_d_reg;
    logic [DATA_W-1:0] key_rd_reg;
    logic [DATA_W-1:0] val_rd_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] s_reg;
    tag_t              where_reg;
    logic [SLOT_W-1:0] rank_s_reg;
    logic [DATA_W-1:0] rdval_reg;

    // Tail and free slot
    logic [SLOT_W-1:0] tail_slot_reg;
    logic              tail_ok_reg;
    tag_t              tail_tag_reg;
    logic [SLOT_W-1:0] free_slot_reg;
    logic              free_ok_reg;

    // Divider
    logic [CNT_W-1:0]     num_reg;
    logic [CNT_W-1:0]     den_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    function automatic logic [1:0] lidx(input tag_t t);
        return 2'(3'(t) - 3'd1);
    endfunction

    function automatic logic [SLOT_W:0] first_set(input logic [SLOTS-1:0] v);
        logic [SLOT_W:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (v[i]) r = {1'b1, SLOT_W'(i)};
        return r;
    endfunction

    // Effective capacity and list sizes
    logic [CAP_W-1:0] c_eff;
    logic [CNT_W-1:0] n1, nb1, nb2, nt2;
    logic [CNT_W:0]   l1, total;
    logic             resident;

    always_comb begin
        if (cap_reg == '0)
            c_eff = CAP_W'(1);
        else if (cap_reg > CAP_W'(CAPACITY))
            c_eff = CAP_W'(CAPACITY);
        else
            c_eff = cap_reg;
        n1    = len_reg[lidx(TAG_T1)];
        nt2   = len_reg[lidx(TAG_T2)];
        nb1   = len_reg[lidx(TAG_B1)];
        nb2   = len_reg[lidx(TAG_B2)];
        l1    = (CNT_W+1)'(n1) + (CNT_W+1)'(nb1);
        total = l1 + (CNT_W+1)'(nt2) + (CNT_W+1)'(nb2);
        resident = (where_reg == TAG_T1) || (where_reg == TAG_T2);
    end

    // Status to the controller
    always_comb begin
        status.scan_done   = (idx_reg == CNT_W'(SLOTS)) && !vld_d_reg;
        status.found       = found_reg;
        status.kind        = kind_reg;
        status.where       = where_reg;
        status.evict_t1    = (n1 != '0) &&
                             ((n1 > CNT_W'(p_reg)) ||
                              ((where_reg == TAG_B2) && (n1 == CNT_W'(p_reg))));
        status.l1_ge_c     = l1 >= (CNT_W+1)'(c_eff);
        status.n1_lt_c     = n1 < CNT_W'(c_eff);
        status.total_ge_c  = total >= (CNT_W+1)'(c_eff);
        status.total_ge_2c = total >= ((CNT_W+1)'(c_eff) << 1);
        status.div_done    = div_cnt_reg == DIV_CNT_W'(DIV_STEPS);
    end

    // Unlink and link requests of this cycle
    logic              u_en, l_en;
    logic [SLOT_W-1:0] u_slot, l_slot, u_rank;
    tag_t              u_tag, l_tag;

    always_comb begin
        u_en   = 1'b0;
        u_slot = s_reg;
        u_tag  = where_reg;
        u_rank = rank_s_reg;
        l_en   = 1'b0;
        l_slot = s_reg;
        l_tag  = cmd.tag;
        unique case (cmd.op)
            OP_UNLINK_S: begin
                u_en = found_reg;
            end
            OP_UNLINK_TAIL: begin
                u_en   = tail_ok_reg;
                u_slot = tail_slot_reg;
                u_tag  = tail_tag_reg;
                u_rank = SLOT_W'(len_reg[lidx(tail_tag_reg)] - CNT_W'(1));
            end
            OP_LINK_S: begin
                l_en = 1'b1;
            end
            OP_LINK_TAIL: begin
                l_en   = tail_ok_reg;
                l_slot = tail_slot_reg;
                l_tag  = (tail_tag_reg == TAG_T1) ? TAG_B1 : TAG_B2;
            end
            OP_LINK_FREE: begin
                l_en   = free_ok_reg;
                l_slot = free_slot_reg;
                l_tag  = TAG_T1;
            end
            default: begin
                u_en = 1'b0;
                l_en = 1'b0;
            end
        endcase
    end

    // Tail and free slot search vectors
    logic [SLOTS-1:0] tail_vec, free_vec;
    logic [SLOT_W:0]  tail_hit, free_hit;
    logic [CNT_W-1:0] tail_len;

    always_comb begin
        tail_len = len_reg[lidx(cmd.tag)];
        for (int i = 0; i < SLOTS; i++) begin
            tail_vec[i] = (tag_reg[i] == cmd.tag) &&
                          (CNT_W'(rank_reg[i]) == tail_len - CNT_W'(1));
            free_vec[i] = tag_reg[i] == TAG_NONE;
        end
        tail_hit = first_set(tail_vec);
        free_hit = first_set(free_vec);
    end

    // Key memory: write on insert, read one slot a cycle during the scan
    logic scan_rd;
    assign scan_rd = (cmd.op == OP_SCAN) && (idx_reg != CNT_W'(SLOTS));

    always_ff @(posedge clk) begin
        if (cmd.op == OP_LINK_FREE && free_ok_reg)
            key_mem[free_slot_reg] <= key_reg;
        if (scan_rd)
            key_rd_reg <= key_mem[idx_reg[SLOT_W-1:0]];
    end

    // Value memory
    logic              val_we;
    logic [SLOT_W-1:0] val_wa;

    always_comb begin
        val_we = 1'b0;
        val_wa = s_reg;
        if (cmd.op == OP_LINK_S && kind_reg)
            val_we = 1'b1;
        else if (cmd.op == OP_LINK_FREE && free_ok_reg) begin
            val_we = 1'b1;
            val_wa = free_slot_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (val_we)
            val_mem[val_wa] <= wval_reg;
        if (scan_rd)
            val_rd_reg <= val_mem[idx_reg[SLOT_W-1:0]];
    end

    // Lists: tags, ranks, lengths and target p
    logic [CNT_W-1:0] d_val;
    logic [CNT_W+1:0] p_sum;

    always_comb begin
        d_val = (quo_reg == '0) ? CNT_W'(1) : quo_reg;
        p_sum = (CNT_W+2)'(p_reg) + (CNT_W+2)'(d_val);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cap_reg <= CAP_W'(CAPACITY);
            p_reg   <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                tag_reg[i]  <= TAG_NONE;
                rank_reg[i] <= '0;
            end
            for (int j = 0; j < 4; j++)
                len_reg[j] <= '0;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
            p_reg   <= '0;
            for (int i = 0; i < SLOTS; i++)
                tag_reg[i] <= TAG_NONE;
            for (int j = 0; j < 4; j++)
                len_reg[j] <= '0;
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (u_en && SLOT_W'(i) != u_slot && tag_reg[i] == u_tag &&
                    rank_reg[i] > u_rank)
                    rank_reg[i] <= rank_reg[i] - SLOT_W'(1);
                if (l_en && tag_reg[i] == l_tag)
                    rank_reg[i] <= rank_reg[i] + SLOT_W'(1);
            end
            if (u_en) begin
                tag_reg[u_slot] <= TAG_NONE;
                if (len_reg[lidx(u_tag)] != '0)
                    len_reg[lidx(u_tag)] <= len_reg[lidx(u_tag)] - CNT_W'(1);
            end
            if (l_en) begin
                tag_reg[l_slot]       <= l_tag;
                rank_reg[l_slot]      <= '0;
                len_reg[lidx(l_tag)]  <= len_reg[lidx(l_tag)] + CNT_W'(1);
            end
            // Adapt p on a ghost hit
            if (cmd.op == OP_ADAPT) begin
                if (where_reg == TAG_B1)
                    p_reg <= (p_sum > (CNT_W+2)'(c_eff)) ? c_eff : CAP_W'(p_sum);
                else if (where_reg == TAG_B2)
                    p_reg <= (CNT_W'(p_reg) > d_val) ? p_reg - CAP_W'(d_val) : '0;
            end
        end
    end

    // Item capture, scan compare, tail and free search, divider
    logic [CNT_W-1:0] trial;
    assign trial = {rem_reg[CNT_W-2:0], num_reg[CNT_W-1]};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg     <= '0;
            vld_d_reg   <= 1'b0;
            found_reg   <= 1'b0;
            where_reg   <= TAG_NONE;
            tail_ok_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            div_cnt_reg <= '0;
            kind_reg    <= 1'b0;
        end else begin
            vld_d_reg <= scan_rd;
            unique case (cmd.op)
                OP_LOAD: begin
                    kind_reg  <= kind;
                    key_reg   <= key;
                    wval_reg  <= write_value;
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    where_reg <= TAG_NONE;
                end
                OP_SCAN: begin
                    if (scan_rd) begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        idx_d_reg <= idx_reg[SLOT_W-1:0];
                    end
                end
                OP_TAIL: begin
                    tail_tag_reg  <= cmd.tag;
                    tail_ok_reg   <= (tail_len != '0) && tail_hit[SLOT_W];
                    tail_slot_reg <= tail_hit[SLOT_W-1:0];
                end
                OP_FREE: begin
                    free_ok_reg   <= free_hit[SLOT_W];
                    free_slot_reg <= free_hit[SLOT_W-1:0];
                end
                OP_DIV_START: begin
                    num_reg     <= (where_reg == TAG_B1) ? nb2 : nb1;
                    den_reg     <= (where_reg == TAG_B1) ?
                                   ((nb1 == '0) ? CNT_W'(1) : nb1) :
                                   ((nb2 == '0) ? CNT_W'(1) : nb2);
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    div_cnt_reg <= '0;
                end
                OP_DIV_STEP: begin
                    if (div_cnt_reg != DIV_CNT_W'(DIV_STEPS)) begin
                        num_reg     <= num_reg << 1;
                        div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                        if (trial >= den_reg) begin
                            rem_reg <= trial - den_reg;
                            quo_reg <= {quo_reg[CNT_W-2:0], 1'b1};
                        end else begin
                            rem_reg <= trial;
                            quo_reg <= {quo_reg[CNT_W-2:0], 1'b0};
                        end
                    end
                end
                default: begin
                end
            endcase
            // Compare the slot read in the previous cycle
            if (vld_d_reg && !found_reg && tag_reg[idx_d_reg] != TAG_NONE &&
                key_rd_reg == key_reg) begin
                found_reg  <= 1'b1;
                s_reg      <= idx_d_reg;
                where_reg  <= tag_reg[idx_d_reg];
                rank_s_reg <= rank_reg[idx_d_reg];
                rdval_reg  <= val_rd_reg;
            end
        end
    end

    // Result fields
    assign hit         = resident;
    assign where_found = 3'(where_reg);
    assign read_value  = (!kind_reg && resident) ? rdval_reg : '0;

endmodule

// ----- sv/arc_ctrl.sv -----
// ----------------------------------------------------------------------------
// arc_ctrl
// Sequencer of one cache operation: key scan, ghost adaptation, drops,
// evictions and the final link, then a one-cycle result strobe.
// ----------------------------------------------------------------------------
module arc_ctrl
    import arc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_DIV,
        ST_ADAPT,
        ST_UNL_S,
        ST_LNK_S,
        ST_EV_TAIL,
        ST_EV_UNL,
        ST_EV_LNK,
        ST_DR_TAIL,
        ST_DR_UNL,
        ST_FREE,
        ST_LNK_FREE,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;
    logic   drop_ev_reg, drop_ev_next;
    tag_t   drop_tag_reg, drop_tag_next;
    logic   resident, ghost;

    assign resident = (status.where == TAG_T1) || (status.where == TAG_T2);
    assign ghost    = (status.where == TAG_B1) || (status.where == TAG_B2);

    // Next state and command
    always_comb begin
        state_next    = state_reg;
        drop_ev_next  = drop_ev_reg;
        drop_tag_next = drop_tag_reg;
        cmd.op        = OP_NOP;
        cmd.tag       = TAG_T2;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.op = OP_SCAN;
                if (status.scan_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!status.kind)
                    state_next = resident ? ST_UNL_S : ST_OUT;
                else if (status.found) begin
                    if (ghost) begin
                        cmd.op     = OP_DIV_START;
                        state_next = ST_DIV;
                    end else
                        state_next = ST_UNL_S;
                end else if (status.l1_ge_c) begin
                    state_next = ST_DR_TAIL;
                    if (status.n1_lt_c) begin
                        drop_tag_next = TAG_B1;
                        drop_ev_next  = 1'b1;
                    end else begin
                        drop_tag_next = TAG_T1;
                        drop_ev_next  = 1'b0;
                    end
                end else if (status.total_ge_c) begin
                    if (status.total_ge_2c) begin
                        drop_tag_next = TAG_B2;
                        drop_ev_next  = 1'b1;
                        state_next    = ST_DR_TAIL;
                    end else
                        state_next = ST_EV_TAIL;
                end else
                    state_next = ST_FREE;
            end
            ST_DIV: begin
                cmd.op = OP_DIV_STEP;
                if (status.div_done)
                    state_next = ST_ADAPT;
            end
            ST_ADAPT: begin
                cmd.op     = OP_ADAPT;
                state_next = ST_UNL_S;
            end
            ST_UNL_S: begin
                cmd.op     = OP_UNLINK_S;
                state_next = (status.kind && ghost) ? ST_EV_TAIL : ST_LNK_S;
            end
            ST_LNK_S: begin
                cmd.op     = OP_LINK_S;
                cmd.tag    = TAG_T2;
                state_next = ST_OUT;
            end
            ST_EV_TAIL: begin
                cmd.op     = OP_TAIL;
                cmd.tag    = status.evict_t1 ? TAG_T1 : TAG_T2;
                state_next = ST_EV_UNL;
            end
            ST_EV_UNL: begin
                cmd.op     = OP_UNLINK_TAIL;
                state_next = ST_EV_LNK;
            end
            ST_EV_LNK: begin
                cmd.op     = OP_LINK_TAIL;
                state_next = status.found ? ST_LNK_S : ST_FREE;
            end
            ST_DR_TAIL: begin
                cmd.op     = OP_TAIL;
                cmd.tag    = drop_tag_reg;
                state_next = ST_DR_UNL;
            end
            ST_DR_UNL: begin
                cmd.op     = OP_UNLINK_TAIL;
                state_next = drop_ev_reg ? ST_EV_TAIL : ST_FREE;
            end
            ST_FREE: begin
                cmd.op     = OP_FREE;
                state_next = ST_LNK_FREE;
            end
            ST_LNK_FREE: begin
                cmd.op     = OP_LINK_FREE;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result strobe
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            drop_ev_reg  <= 1'b0;
            drop_tag_reg <= TAG_B1;
        end else begin
            state_reg    <= state_next;
            done_reg     <= state_next == ST_OUT;
            drop_ev_reg  <= drop_ev_next;
            drop_tag_reg <= drop_tag_next;
        end
    end

    assign busy = state_reg != ST_IDLE;
    assign done = done_reg;

endmodule

// ----- sv/adaptive_replacement_cache_core.sv -----
// ----------------------------------------------------------------------------
// adaptive_replacement_cache_core
// ARC key/value cache with two resident lists, two ghost lists and an
// adaptive T1 target, built as a sequencer over a slot datapath.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Fields
// input     in         start & !busy      kind, key, write_value
// result    out        done (one cycle)   hit, where_found, read_value
// config    in         cfg_we             cfg_wdata (capacity_in_use)
//
// A get miss is the shortest item. The key search reads the slot key memory
// one slot a cycle (2*CAPACITY slots, then the compare of the last slot read),
// and a ghost put adds a serial divide of six steps plus the eviction steps.
// busy stays high from acceptance through the done cycle.
// Reset empties all lists, clears p and sets the capacity to CAPACITY.
// The receiver cannot stall: each result shows on done for one cycle.
// ----------------------------------------------------------------------------
module adaptive_replacement_cache_core
    import arc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     kind,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] write_value,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_wdata,
    output logic                     done,
    output logic                     hit,
    output logic [2:0]               where_found,
    output logic signed [DATA_W-1:0] read_value
);

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [DATA_W-1:0] rd_val;

    arc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    arc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .kind        (kind),
        .key         (key),
        .write_value (write_value),
        .cmd         (cmd),
        .status      (status),
        .hit         (hit),
        .where_found (where_found),
        .read_value  (rd_val)
    );

    assign read_value = signed'(rd_val);

    // A result only closes an item in progress
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe outside an item");

    // The strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // An accepted item keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("item accepted without going busy");

    // A hit comes only from a resident list
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (where_found == 3'(TAG_T1) || where_found == 3'(TAG_T2)))
        else $error("hit reported from a non-resident list");

endmodule
